/* design/xid_pkg.sv */
package xid_pkg;

  localparam int MaxInstrBytes = 6;
  localparam int CntW = 3;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StUnknown   = 2'd1;
  localparam logic [1:0] StInvalid   = 2'd2;
  localparam logic [1:0] StTruncated = 2'd3;

  localparam logic [3:0] ClsMovRegRm  = 4'd0;
  localparam logic [3:0] ClsMovSeg    = 4'd1;
  localparam logic [3:0] ClsMovImmRm  = 4'd2;
  localparam logic [3:0] ClsMovImmReg = 4'd3;
  localparam logic [3:0] ClsMovAcc    = 4'd4;
  localparam logic [3:0] ClsAluRm     = 4'd5;
  localparam logic [3:0] ClsAluImmRm  = 4'd6;
  localparam logic [3:0] ClsAluImmAcc = 4'd7;
  localparam logic [3:0] ClsJcc       = 4'd8;
  localparam logic [3:0] ClsLoop      = 4'd9;
  localparam logic [3:0] ClsNone      = 4'd15;

  // Decoded instruction record, also the payload of the result channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  instr_class;
    logic [3:0]  operation;
    logic        is_wide;
    logic        reg_is_dest;
    logic [2:0]  reg_code;
    logic [1:0]  mode;
    logic [2:0]  rm_code;
    logic [15:0] disp_or_addr;
    logic [15:0] immediate;
    logic [8:0]  jump_offset;
    logic [2:0]  length;
  } dec_t;

  function automatic logic [3:0] opcode_class(input logic [7:0] b0);
    logic [3:0] c;
    c = ClsNone;
    if ((b0 & 8'hFC) == 8'h88) c = ClsMovRegRm;
    else if (b0 == 8'h8C || b0 == 8'h8E) c = ClsMovSeg;
    else if ((b0 & 8'hFE) == 8'hC6) c = ClsMovImmRm;
    else if ((b0 & 8'hF0) == 8'hB0) c = ClsMovImmReg;
    else if ((b0 & 8'hFC) == 8'hA0) c = ClsMovAcc;
    else if ((b0 & 8'hC4) == 8'h00) c = ClsAluRm;
    else if ((b0 & 8'hFC) == 8'h80) c = ClsAluImmRm;
    else if ((b0 & 8'hC6) == 8'h04) c = ClsAluImmAcc;
    else if ((b0 & 8'hF0) == 8'h70) c = ClsJcc;
    else if ((b0 & 8'hFC) == 8'hE0) c = ClsLoop;
    return c;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

/* design/xid_front.sv */
module xid_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      code_byte,
  input  logic            is_last_byte,
  output logic            q_push,
  output xid_pkg::dec_t   q_data,
  input  logic            q_full
);

  logic [7:0] buf_r [xid_pkg::MaxInstrBytes];
  logic [xid_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic halted_r, halted_nxt;

  logic [7:0] b [xid_pkg::MaxInstrBytes];
  logic [xid_pkg::CntW-1:0] cnt1;
  logic [3:0] cls;
  logic [1:0] md;
  logic [2:0] rg, rmv;
  logic w, sbit;
  logic [2:0] nd, need;
  logic has_modrm;
  logic [15:0] dsp, imm;
  logic [8:0] joff;
  xid_pkg::dec_t d;
  logic emit;

  assign in_ready = !halted_r && !q_full;
  assign cnt1 = cnt_r + 3'd1;

  // View of the buffer with the arriving byte already in place.
  always_comb begin
    for (int i = 0; i < xid_pkg::MaxInstrBytes; i++) begin
      b[i] = (cnt_r == 3'(i)) ? code_byte : buf_r[i];
    end
  end

  function automatic logic [15:0] word_at(input logic [7:0] lo, input logic [7:0] hi);
    return {hi, lo};
  endfunction

  always_comb begin
    logic [7:0] bimm_lo, bimm_hi;
    cls = xid_pkg::opcode_class(b[0]);
    md = b[1][7:6];
    rg = b[1][5:3];
    rmv = b[1][2:0];
    w = b[0][0];
    sbit = b[0][1];
    case (md)
      2'd0: nd = (rmv == 3'd6) ? 3'd2 : 3'd0;
      2'd1: nd = 3'd1;
      2'd2: nd = 3'd2;
      default: nd = 3'd0;
    endcase
    // Immediate bytes that follow the displacement.
    case (nd)
      3'd1: begin bimm_lo = b[3]; bimm_hi = b[4]; end
      3'd2: begin bimm_lo = b[4]; bimm_hi = b[5]; end
      default: begin bimm_lo = b[2]; bimm_hi = b[3]; end
    endcase
    d = '0;
    d.status = xid_pkg::StOk;
    d.instr_class = cls;
    has_modrm = 1'b0;
    need = 3'd2;
    dsp = '0;
    imm = '0;
    joff = '0;
    unique case (cls)
      xid_pkg::ClsMovRegRm, xid_pkg::ClsAluRm: begin
        has_modrm = 1'b1; need = 3'd2 + nd;
        d.reg_is_dest = b[0][1]; d.reg_code = rg; d.is_wide = w;
        if (cls == xid_pkg::ClsAluRm) d.operation = {1'b0, b[0][5:3]};
      end
      xid_pkg::ClsMovSeg: begin
        has_modrm = 1'b1; need = 3'd2 + nd;
        d.reg_is_dest = b[0][1]; d.reg_code = rg; d.is_wide = 1'b1;
      end
      xid_pkg::ClsMovImmRm: begin
        has_modrm = 1'b1; need = 3'd2 + nd + (w ? 3'd2 : 3'd1);
        d.is_wide = w;
        imm = w ? word_at(bimm_lo, bimm_hi) : {8'd0, bimm_lo};
      end
      xid_pkg::ClsMovImmReg: begin
        d.is_wide = b[0][3]; d.reg_code = b[0][2:0];
        need = b[0][3] ? 3'd3 : 3'd2;
        imm = b[0][3] ? word_at(b[1], b[2]) : {8'd0, b[1]};
      end
      xid_pkg::ClsMovAcc: begin
        d.is_wide = w; d.reg_is_dest = b[0][1]; need = 3'd3;
        dsp = word_at(b[1], b[2]);
      end
      xid_pkg::ClsAluImmRm: begin
        has_modrm = 1'b1; d.is_wide = w; d.operation = {1'b0, rg};
        need = 3'd2 + nd + ((w && !sbit) ? 3'd2 : 3'd1);
        if (w && !sbit) imm = word_at(bimm_lo, bimm_hi);
        else if (w) imm = xid_pkg::sext8(bimm_lo);
        else imm = {8'd0, bimm_lo};
      end
      xid_pkg::ClsAluImmAcc: begin
        d.is_wide = w; d.operation = {1'b0, b[0][5:3]};
        need = w ? 3'd3 : 3'd2;
        imm = w ? word_at(b[1], b[2]) : {8'd0, b[1]};
      end
      xid_pkg::ClsJcc, xid_pkg::ClsLoop: begin
        d.operation = (cls == xid_pkg::ClsJcc) ? b[0][3:0] : {2'b0, b[0][1:0]};
        joff = {b[1][7], b[1]} + 9'd2;
      end
      default: ;
    endcase
    if (has_modrm) begin
      d.mode = md; d.rm_code = rmv;
      if (nd == 3'd1) dsp = xid_pkg::sext8(b[2]);
      else if (nd == 3'd2) dsp = word_at(b[2], b[3]);
    end
    d.disp_or_addr = dsp;
    d.immediate = imm;
    d.jump_offset = joff;
    d.length = need;
  end

  always_comb begin
    emit = 1'b0;
    q_data = d;
    cnt_nxt = cnt1;
    halted_nxt = halted_r;
    if (cnt1 < 3'd2) begin
      if (is_last_byte) begin
        emit = 1'b1; q_data = '0; q_data.status = xid_pkg::StTruncated;
      end
    end else if (cls == xid_pkg::ClsNone) begin
      emit = 1'b1; q_data = '0; q_data.status = xid_pkg::StUnknown;
    end else if ((cls == xid_pkg::ClsMovSeg && rg[2]) ||
                 (cls == xid_pkg::ClsMovImmRm && (rg != 3'd0 || md == 2'd3))) begin
      emit = 1'b1; q_data = '0; q_data.status = xid_pkg::StInvalid;
    end else if (cnt1 >= need) begin
      emit = 1'b1; cnt_nxt = '0;
    end else if (is_last_byte) begin
      emit = 1'b1; q_data = '0; q_data.status = xid_pkg::StTruncated;
    end
    if (emit && q_data.status != xid_pkg::StOk) begin
      halted_nxt = 1'b1; cnt_nxt = '0;
    end
  end

  assign q_push = in_valid && in_ready && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      halted_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      cnt_r <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cnt_r < 3'(xid_pkg::MaxInstrBytes)) begin
      buf_r[cnt_r] <= code_byte;
    end
  end

endmodule

/* design/xid_queue.sv */
module xid_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xid_pkg::dec_t push_data,
  output logic          full,
  output logic          out_tvalid,
  input  logic          out_tready,
  output xid_pkg::dec_t out_data
);

  // Two-entry queue; the head entry drives the result channel directly.
  xid_pkg::dec_t mem_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic pop;

  assign pop = out_tvalid && out_tready;
  assign full = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

/* design/x86_16bit_instruction_decoder_top.sv */
// 8086 subset instruction decoder.
// Input channel: one code byte per transfer; in_tlast marks the final byte of
// the code stream. Result channel: one decoded instruction per transfer, or an
// error record whose status is nonzero and whose other fields are zero.
// The result of an instruction is written into the queue at the transfer of its
// final byte. Throughput: one byte per cycle while in_tready is high; a byte that
// completes an instruction is taken in the same cycle as any other.
// The front end collects bytes and decodes on the fly; a two-entry queue holds
// finished results, so the byte stream keeps flowing while one result waits.
// When the receiver stalls and the queue fills, in_tready falls until a result
// is taken.
// After an error the block drops in_tready for good and stays halted until
// reset. Reset clears the byte count, the halt flag and the queue.
module x86_16bit_instruction_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // code_byte
  input  logic        in_tlast,   // is_last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status, instr_class, operation, is_wide,
                                  // reg_is_dest, reg_code, mode, rm_code,
                                  // disp_or_addr, immediate, jump_offset, length
);

  logic q_push, q_full;
  xid_pkg::dec_t q_in, q_out;

  xid_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .code_byte(in_tdata), .is_last_byte(in_tlast),
    .q_push, .q_data(q_in), .q_full
  );

  xid_queue u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data(q_in), .full(q_full),
    .out_tvalid, .out_tready, .out_data(q_out)
  );

  assign out_tdata = {q_out.length, q_out.jump_offset, q_out.immediate,
                      q_out.disp_or_addr, q_out.rm_code, q_out.mode, q_out.reg_code,
                      q_out.reg_is_dest, q_out.is_wide, q_out.operation,
                      q_out.instr_class, q_out.status};

endmodule

/* design/xid_checker.sv */
module xid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[63:2] == '0)
    else $error("error record carries data");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd0 |-> out_tdata[63:61] >= 3'd2 &&
      out_tdata[63:61] <= 3'd6 && out_tdata[5:2] <= 4'd9)
    else $error("bad length or class");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[1:0] != 2'd0 |=> !in_tready)
    else $error("accepting input after error");

endmodule

bind x86_16bit_instruction_decoder_top xid_checker u_xid_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
